// ----- hdl/npl_pkg.sv -----
package npl_pkg;

	localparam int MAX_RECORD_BYTES = 65535;
	localparam int POS_W = $clog2(MAX_RECORD_BYTES + 1);
	localparam int LEN_W = 16;
	localparam int OFF_W = (POS_W + 1 > LEN_W + 1) ? POS_W + 1 : LEN_W + 1;
	localparam int NXT_W = (POS_W > LEN_W + 1) ? POS_W + 1 : LEN_W + 2;

	localparam int RECORD_HDR_BYTES = 4;
	localparam int ATTR_HDR_BYTES = 4;
	localparam logic [14:0] ATTR_TYPE_MASK = 15'h7FFF;
	localparam logic [14:0] ATTR_TYPE_PAYLOAD = 15'd9;

	localparam logic [1:0] HDR_LEN_LO = 2'd0;
	localparam logic [1:0] HDR_LEN_HI = 2'd1;
	localparam logic [1:0] HDR_TYPE_LO = 2'd2;
	localparam logic [1:0] HDR_TYPE_HI = 2'd3;

	typedef struct packed {
		logic found;
		logic [15:0] payload_offset;
		logic [15:0] payload_length;
	} npl_res_t;

endpackage

// ----- hdl/npl_byte_if.sv -----
interface npl_byte_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink (input valid, input data_byte, input last, output ready);
endinterface

// ----- hdl/npl_result_if.sv -----
interface npl_result_if;
	logic valid;
	logic ready;
	logic found;
	logic [15:0] payload_offset;
	logic [15:0] payload_length;

	modport source (output valid, output found, output payload_offset, output payload_length,
		input ready);
	modport sink (input valid, input found, input payload_offset, input payload_length,
		output ready);
endinterface

// ----- hdl/npl_walker.sv -----
module npl_walker (
	input logic clk,
	input logic arst_n,
	npl_byte_if.sink byte_ch,
	input logic take_ok,
	output logic res_valid,
	output npl_pkg::npl_res_t res
);
	import npl_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] nhs_q;
	logic [23:0] hdr_q;
	logic given_q;
	logic stopped_q;

	logic accept;
	logic [POS_W-1:0] diff;
	logic in_hdr;
	logic [1:0] k;
	logic [15:0] alen;
	logic [14:0] atype;
	logic short_len;
	logic hit;
	logic [OFF_W-1:0] off_sum;
	logic [15:0] off_sat;
	logic [LEN_W:0] alen_round;
	logic [NXT_W-1:0] nxt_sum;
	logic [POS_W-1:0] nxt_sat;

	assign byte_ch.ready = take_ok;
	assign accept = byte_ch.valid && take_ok;

	assign diff = pos_q - nhs_q;
	assign in_hdr = !given_q && !stopped_q && (pos_q < POS_W'(MAX_RECORD_BYTES))
		&& (pos_q >= nhs_q) && (diff < POS_W'(ATTR_HDR_BYTES));
	assign k = diff[1:0];
	assign alen = hdr_q[15:0];
	assign atype = 15'({byte_ch.data_byte, hdr_q[23:16]}) & ATTR_TYPE_MASK;
	assign short_len = alen < 16'(ATTR_HDR_BYTES);
	assign hit = in_hdr && (k == HDR_TYPE_HI) && !short_len && (atype == ATTR_TYPE_PAYLOAD);

	assign off_sum = OFF_W'(nhs_q) + OFF_W'(ATTR_HDR_BYTES);
	assign off_sat = (off_sum > OFF_W'(16'hFFFF)) ? 16'hFFFF : off_sum[15:0];

	assign alen_round = (17'(alen) + 17'd3) & ~17'd3;
	assign nxt_sum = NXT_W'(nhs_q) + NXT_W'(alen_round);
	assign nxt_sat = (nxt_sum > NXT_W'(MAX_RECORD_BYTES)) ? POS_W'(MAX_RECORD_BYTES)
		: nxt_sum[POS_W-1:0];

	always_comb begin
		res_valid = accept && (hit || (byte_ch.last && !given_q));
		res.found = hit;
		res.payload_offset = hit ? off_sat : 16'd0;
		res.payload_length = hit ? (alen - 16'(ATTR_HDR_BYTES)) : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			nhs_q <= POS_W'(RECORD_HDR_BYTES);
			given_q <= 1'b0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			if (byte_ch.last) begin
				pos_q <= '0;
				nhs_q <= POS_W'(RECORD_HDR_BYTES);
				given_q <= 1'b0;
				stopped_q <= 1'b0;
			end else begin
				if (pos_q < POS_W'(MAX_RECORD_BYTES)) begin
					pos_q <= pos_q + 1'b1;
				end
				if (in_hdr && (k == HDR_TYPE_HI)) begin
					if (short_len) begin
						stopped_q <= 1'b1;
					end else if (hit) begin
						given_q <= 1'b1;
					end else begin
						nhs_q <= nxt_sat;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_hdr) begin
			unique case (k)
				HDR_LEN_LO: hdr_q[7:0] <= byte_ch.data_byte;
				HDR_LEN_HI: hdr_q[15:8] <= byte_ch.data_byte;
				HDR_TYPE_LO: hdr_q[23:16] <= byte_ch.data_byte;
				HDR_TYPE_HI: ;
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(given_q && stopped_q))
		else $error("walk both stopped and found");
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(MAX_RECORD_BYTES))
		else $error("position beyond bound");
	a_one_found: assert property (@(posedge clk) disable iff (!arst_n)
		given_q |-> !hit)
		else $error("second found in one record");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && byte_ch.last) |=> (pos_q == '0 && !given_q && !stopped_q))
		else $error("state not cleared after last beat");
`endif

endmodule

// ----- hdl/npl_out_stage.sv -----
module npl_out_stage (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input npl_pkg::npl_res_t res,
	output logic take_ok,
	npl_result_if.source result_ch
);
	import npl_pkg::*;

	logic valid_q;
	npl_res_t res_q;

	assign take_ok = !valid_q || result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_ok) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_ok && res_valid) begin
			res_q <= res;
		end
	end

	assign result_ch.valid = valid_q;
	assign result_ch.found = res_q.found;
	assign result_ch.payload_offset = res_q.payload_offset;
	assign result_ch.payload_length = res_q.payload_length;

`ifndef SYNTHESIS
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !take_ok) |-> 1'b0)
		else $error("result offered while output stalled");
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !res_q.found) |-> (res_q.payload_offset == 16'd0
		&& res_q.payload_length == 16'd0))
		else $error("not-found result with nonzero fields");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !result_ch.ready) |=> (valid_q && $stable(res_q)))
		else $error("stalled result changed");
`endif

endmodule

// ----- hdl/nflog_payload_locator_core.sv -----
// NFLOG payload locator.
// byte_ch (sink): one record byte per beat, last marks the final byte.
// result_ch (source): one beat per record: found with payload offset and
// length when the payload attribute header completes, otherwise a not-found
// beat (all zero) on the last byte. Bytes after a found beat are consumed
// silently up to the last byte, which then gives no beat.
// Throughput: one byte per cycle unless stalled. Each byte is decoded in the
// cycle it is accepted and its result is captured by the output register.
// The output register is the only buffering: byte_ch.ready is high while that
// register is empty or being read, so a stalled receiver holds off input only
// once a result is waiting.
// Reset (arst_n low, asynchronous) empties the output register and returns
// the walker to the start of a record; the block is ready as soon as
// reset is released.
module nflog_payload_locator_core (
	input logic clk,
	input logic arst_n,
	npl_byte_if.sink byte_ch,
	npl_result_if.source result_ch
);
	import npl_pkg::*;

	logic take_ok;
	logic res_valid;
	npl_res_t res;

	npl_walker u_walker (
		.clk(clk),
		.arst_n(arst_n),
		.byte_ch(byte_ch),
		.take_ok(take_ok),
		.res_valid(res_valid),
		.res(res)
	);

	npl_out_stage u_out_stage (
		.clk(clk),
		.arst_n(arst_n),
		.res_valid(res_valid),
		.res(res),
		.take_ok(take_ok),
		.result_ch(result_ch)
	);

endmodule
